### rtl/core/cbc_pkg.sv
// Shared constants for the circle versus box collision block.
// No dependencies; imported by every module of the block.
package cbc_pkg;

  localparam int unsigned RED_BITS     = 16;
  localparam int unsigned LEN_EXTRA    = 15;
  localparam int unsigned LEN_BITS     = RED_BITS + LEN_EXTRA + 1;
  localparam int unsigned NORMAL_WIDTH = 16;

endpackage

### rtl/core/cbc_sqrt_cell.sv
// One cell of the digit-by-digit square root chain: settles one root bit per cell.
// Depends on cbc_pkg.
module cbc_sqrt_cell #(
  parameter int unsigned N = 26,
  parameter int unsigned P = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [2*N-1:0] rad_i,
  input  logic [N+1:0]   rem_i,
  input  logic [N-1:0]   root_i,
  input  logic [P-1:0]   pay_i,
  output logic           valid_o,
  output logic [2*N-1:0] rad_o,
  output logic [N+1:0]   rem_o,
  output logic [N-1:0]   root_o,
  output logic [P-1:0]   pay_o
);
  import cbc_pkg::*;

  logic [N+3:0]   next_rem;
  logic [N+3:0]   trial;
  logic [N+3:0]   diff;
  logic           ge;
  logic [N+1:0]   rem_d;
  logic [N-1:0]   root_d;
  logic [2*N-1:0] rad_d;
  logic           valid_q;
  logic [2*N-1:0] rad_q;
  logic [N+1:0]   rem_q;
  logic [N-1:0]   root_q;
  logic [P-1:0]   pay_q;

  always_comb begin
    next_rem = {rem_i, rad_i[2*N-1 -: 2]};
    trial    = {2'b00, root_i, 2'b01};
    diff     = next_rem - trial;
    ge       = (next_rem >= trial);
    rem_d    = ge ? diff[N+1:0] : next_rem[N+1:0];
    root_d   = {root_i[N-2:0], ge};
    rad_d    = {rad_i[2*N-3:0], 2'b00};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

### rtl/core/cbc_div_cell.sv
// One cell of the restoring divider chain: one quotient bit for each of two lanes.
// Depends on cbc_pkg.
module cbc_div_cell #(
  parameter int unsigned DW = 46,
  parameter int unsigned Q  = 15,
  parameter int unsigned P  = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] ds_i,
  input  logic [DW-1:0] rx_i,
  input  logic [DW-1:0] ry_i,
  input  logic [Q-1:0]  qx_i,
  input  logic [Q-1:0]  qy_i,
  input  logic [P-1:0]  pay_i,
  output logic          valid_o,
  output logic [DW-1:0] ds_o,
  output logic [DW-1:0] rx_o,
  output logic [DW-1:0] ry_o,
  output logic [Q-1:0]  qx_o,
  output logic [Q-1:0]  qy_o,
  output logic [P-1:0]  pay_o
);
  import cbc_pkg::*;

  logic          gx;
  logic          gy;
  logic          valid_q;
  logic [DW-1:0] ds_q;
  logic [DW-1:0] rx_q;
  logic [DW-1:0] ry_q;
  logic [Q-1:0]  qx_q;
  logic [Q-1:0]  qy_q;
  logic [P-1:0]  pay_q;

  assign gx = (rx_i >= ds_i);
  assign gy = (ry_i >= ds_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ds_q  <= ds_i >> 1;
      rx_q  <= gx ? (rx_i - ds_i) : rx_i;
      ry_q  <= gy ? (ry_i - ds_i) : ry_i;
      qx_q  <= {qx_i[Q-2:0], gx};
      qy_q  <= {qy_i[Q-2:0], gy};
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign ds_o    = ds_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign qx_o    = qx_q;
  assign qy_o    = qy_q;
  assign pay_o   = pay_q;

endmodule

### rtl/core/circle_box_collision_top.sv
// Top level of the circle versus axis-aligned box collision block.
// Depends on cbc_pkg, cbc_sqrt_cell and cbc_div_cell.
// A beat passes stages 1 to 4, the distance square root chain, stages 5 to 7,
// the length square root chain, stage 8, the divider chain and the output register.
// Throughput: one beat per cycle; the whole pipeline holds only while the output
// register is full and not taken. Reset clears every valid flag; no clearing pass.
module circle_box_collision_top #(
  parameter int unsigned COORD_BITS       = 24,
  parameter int unsigned FRAC_BITS        = 8,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // box_center_x, box_center_y, box_width, box_height, circle_x, circle_y,
  // circle_radius, then zero padding
  input  logic [((4*COORD_BITS+3*(COORD_BITS-1)+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // hit, contact_x, contact_y, normal_x, normal_y, depth, then zero padding
  output logic [((1+2*COORD_BITS+2*cbc_pkg::NORMAL_WIDTH+COORD_BITS-1+7)/8)*8-1:0]
    m_axis_tdata_o
);
  import cbc_pkg::*;

  localparam int unsigned CB        = COORD_BITS;
  localparam int unsigned SB        = COORD_BITS - 1;
  localparam int unsigned EW        = COORD_BITS + 1;
  localparam int unsigned N1        = COORD_BITS + 1;
  localparam int unsigned Q         = NORMAL_FRAC_BITS + 1;
  localparam int unsigned DW        = LEN_BITS + NORMAL_FRAC_BITS;
  localparam int unsigned NW        = Q + NORMAL_WIDTH;
  localparam int unsigned NEAR_ZERO = (1 << FRAC_BITS) / 10000;
  localparam int unsigned OUT_W     = 1 + 2*CB + 2*NORMAL_WIDTH + SB;
  localparam int unsigned OUT_TW    = ((OUT_W + 7) / 8) * 8;

  typedef struct packed {
    logic          sx;
    logic          sy;
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [CB-1:0] ax;
    logic [CB-1:0] ay;
    logic [SB-1:0] rad;
  } p1_t;

  typedef struct packed {
    logic                hit;
    logic                near;
    logic                sx;
    logic                sy;
    logic [CB-1:0]       px;
    logic [CB-1:0]       py;
    logic [SB-1:0]       depth;
    logic [RED_BITS-1:0] rx;
    logic [RED_BITS-1:0] ry;
  } p2_t;

  typedef struct packed {
    logic          hit;
    logic          near;
    logic          sx;
    logic          sy;
    logic [CB-1:0] px;
    logic [CB-1:0] py;
    logic [SB-1:0] depth;
  } p4_t;

  localparam int unsigned P1 = $bits(p1_t);
  localparam int unsigned P2 = $bits(p2_t);
  localparam int unsigned P4 = $bits(p4_t);

  logic en;

  // Stage 1: box edges.
  logic                 v1_q;
  logic signed [EW-1:0] lox_q, hix_q, loy_q, hiy_q;
  logic        [CB-1:0] cx1_q, cy1_q;
  logic        [SB-1:0] rad1_q;
  logic signed [EW-1:0] hw, hh, bxe, bye;

  // Stage 2: closest point and offset.
  logic                 v2_q;
  p1_t                  p2s_q;
  logic signed [EW-1:0] cxe, cye, pxe, pye, dxe, dye, axe, aye;

  // Stage 3: squares.
  logic                 v3_q;
  p1_t                  p3s_q;
  logic [2*CB-1:0]      sqx_q, sqy_q;

  // Stage 4: squared distance.
  logic                 v4_q;
  p1_t                  p4s_q;
  logic [2*N1-1:0]      r4_q;

  logic            c1_v    [N1+1];
  logic [2*N1-1:0] c1_rad  [N1+1];
  logic [N1+1:0]   c1_rem  [N1+1];
  logic [N1-1:0]   c1_root [N1+1];
  logic [P1-1:0]   c1_pay  [N1+1];

  // Stage 5: hit test and offset reduction.
  p1_t                 q1;
  logic [N1-1:0]       dist_root;
  logic [CB-1:0]       orv;
  int unsigned         lenv;
  int unsigned         shv;
  logic                v5_q;
  p2_t                 p5_q;
  p2_t                 p5_d;

  // Stage 6 and 7: reduced squares and length radicand.
  logic                  v6_q;
  p2_t                   p6_q;
  logic [2*RED_BITS-1:0] mx_q, my_q;
  logic                  v7_q;
  p2_t                   p7_q;
  logic [2*LEN_BITS-1:0] r7_q;

  logic                  c2_v    [LEN_BITS+1];
  logic [2*LEN_BITS-1:0] c2_rad  [LEN_BITS+1];
  logic [LEN_BITS+1:0]   c2_rem  [LEN_BITS+1];
  logic [LEN_BITS-1:0]   c2_root [LEN_BITS+1];
  logic [P2-1:0]         c2_pay  [LEN_BITS+1];

  // Stage 8: dividends and divisor.
  p2_t                 q2;
  logic [LEN_BITS-1:0] len;
  logic                v8_q;
  p4_t                 p8_q;
  logic [DW-1:0]       ds8_q, nx8_q, ny8_q;

  logic          d_v   [Q+1];
  logic [DW-1:0] d_ds  [Q+1];
  logic [DW-1:0] d_rx  [Q+1];
  logic [DW-1:0] d_ry  [Q+1];
  logic [Q-1:0]  d_qx  [Q+1];
  logic [Q-1:0]  d_qy  [Q+1];
  logic [P4-1:0] d_pay [Q+1];

  // Output register.
  p4_t                     q4;
  logic [NW-1:0]           nxw, nyw, onew;
  logic                    out_v_q;
  logic                    hit_q;
  logic [CB-1:0]           ocx_q, ocy_q;
  logic [NORMAL_WIDTH-1:0] onx_q, ony_q;
  logic [SB-1:0]           odep_q;

  assign en              = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_comb begin
    hw  = $signed({3'b000, s_axis_tdata_i[2*CB+1 +: SB-1]});
    hh  = $signed({3'b000, s_axis_tdata_i[2*CB+SB+1 +: SB-1]});
    bxe = $signed({s_axis_tdata_i[CB-1], s_axis_tdata_i[CB-1:0]});
    bye = $signed({s_axis_tdata_i[2*CB-1], s_axis_tdata_i[2*CB-1:CB]});
  end

  always_comb begin
    cxe = $signed({cx1_q[CB-1], cx1_q});
    cye = $signed({cy1_q[CB-1], cy1_q});
    pxe = (cxe < lox_q) ? lox_q : ((cxe > hix_q) ? hix_q : cxe);
    pye = (cye < loy_q) ? loy_q : ((cye > hiy_q) ? hiy_q : cye);
    dxe = pxe - cxe;
    dye = pye - cye;
    axe = dxe[EW-1] ? -dxe : dxe;
    aye = dye[EW-1] ? -dye : dye;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid_i;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      v5_q    <= c1_v[N1];
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= c2_v[LEN_BITS];
      out_v_q <= d_v[Q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lox_q  <= bxe - hw;
      hix_q  <= bxe + hw;
      loy_q  <= bye - hh;
      hiy_q  <= bye + hh;
      cx1_q  <= s_axis_tdata_i[2*CB+2*SB +: CB];
      cy1_q  <= s_axis_tdata_i[3*CB+2*SB +: CB];
      rad1_q <= s_axis_tdata_i[4*CB+2*SB +: SB];

      p2s_q.sx  <= dxe[EW-1];
      p2s_q.sy  <= dye[EW-1];
      p2s_q.px  <= pxe[CB-1:0];
      p2s_q.py  <= pye[CB-1:0];
      p2s_q.ax  <= axe[CB-1:0];
      p2s_q.ay  <= aye[CB-1:0];
      p2s_q.rad <= rad1_q;

      p3s_q <= p2s_q;
      sqx_q <= p2s_q.ax * p2s_q.ax;
      sqy_q <= p2s_q.ay * p2s_q.ay;

      p4s_q <= p3s_q;
      r4_q  <= {1'b0, {1'b0, sqx_q} + {1'b0, sqy_q}};
    end
  end

  assign c1_v[0]    = v4_q;
  assign c1_rad[0]  = r4_q;
  assign c1_rem[0]  = '0;
  assign c1_root[0] = '0;
  assign c1_pay[0]  = p4s_q;

  for (genvar k = 0; k < N1; k++) begin : g_sqrt_a
    cbc_sqrt_cell #(.N(N1), .P(P1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c1_v[k]),
      .rad_i   (c1_rad[k]),
      .rem_i   (c1_rem[k]),
      .root_i  (c1_root[k]),
      .pay_i   (c1_pay[k]),
      .valid_o (c1_v[k+1]),
      .rad_o   (c1_rad[k+1]),
      .rem_o   (c1_rem[k+1]),
      .root_o  (c1_root[k+1]),
      .pay_o   (c1_pay[k+1])
    );
  end

  always_comb begin
    q1        = p1_t'(c1_pay[N1]);
    dist_root = c1_root[N1];
    orv       = q1.ax | q1.ay;
    lenv      = 0;
    for (int i = 0; i < CB; i++) begin
      if (orv[i]) begin
        lenv = i + 1;
      end
    end
    shv = (lenv > RED_BITS) ? (lenv - RED_BITS) : 0;
    p5_d.hit   = (dist_root <= N1'(q1.rad));
    p5_d.near  = (dist_root <= N1'(NEAR_ZERO));
    p5_d.sx    = q1.sx;
    p5_d.sy    = q1.sy;
    p5_d.px    = q1.px;
    p5_d.py    = q1.py;
    p5_d.depth = q1.rad - dist_root[SB-1:0];
    p5_d.rx    = RED_BITS'(q1.ax >> shv);
    p5_d.ry    = RED_BITS'(q1.ay >> shv);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q <= p5_d;
      p6_q <= p5_q;
      mx_q <= p5_q.rx * p5_q.rx;
      my_q <= p5_q.ry * p5_q.ry;
      p7_q <= p6_q;
      r7_q <= {1'b0, {1'b0, mx_q} + {1'b0, my_q}, {(2*LEN_EXTRA){1'b0}}};
    end
  end

  assign c2_v[0]    = v7_q;
  assign c2_rad[0]  = r7_q;
  assign c2_rem[0]  = '0;
  assign c2_root[0] = '0;
  assign c2_pay[0]  = p7_q;

  for (genvar k = 0; k < LEN_BITS; k++) begin : g_sqrt_b
    cbc_sqrt_cell #(.N(LEN_BITS), .P(P2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c2_v[k]),
      .rad_i   (c2_rad[k]),
      .rem_i   (c2_rem[k]),
      .root_i  (c2_root[k]),
      .pay_i   (c2_pay[k]),
      .valid_o (c2_v[k+1]),
      .rad_o   (c2_rad[k+1]),
      .rem_o   (c2_rem[k+1]),
      .root_o  (c2_root[k+1]),
      .pay_o   (c2_pay[k+1])
    );
  end

  always_comb begin
    q2  = p2_t'(c2_pay[LEN_BITS]);
    len = (c2_root[LEN_BITS] == '0) ? LEN_BITS'(1) : c2_root[LEN_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p8_q.hit   <= q2.hit;
      p8_q.near  <= q2.near;
      p8_q.sx    <= q2.sx;
      p8_q.sy    <= q2.sy;
      p8_q.px    <= q2.px;
      p8_q.py    <= q2.py;
      p8_q.depth <= q2.depth;
      ds8_q <= DW'(len) << NORMAL_FRAC_BITS;
      nx8_q <= (DW'(q2.rx) << (NORMAL_FRAC_BITS + LEN_EXTRA)) + DW'(len >> 1);
      ny8_q <= (DW'(q2.ry) << (NORMAL_FRAC_BITS + LEN_EXTRA)) + DW'(len >> 1);
    end
  end

  assign d_v[0]   = v8_q;
  assign d_ds[0]  = ds8_q;
  assign d_rx[0]  = nx8_q;
  assign d_ry[0]  = ny8_q;
  assign d_qx[0]  = '0;
  assign d_qy[0]  = '0;
  assign d_pay[0] = p8_q;

  for (genvar k = 0; k < Q; k++) begin : g_div
    cbc_div_cell #(.DW(DW), .Q(Q), .P(P4)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (d_v[k]),
      .ds_i    (d_ds[k]),
      .rx_i    (d_rx[k]),
      .ry_i    (d_ry[k]),
      .qx_i    (d_qx[k]),
      .qy_i    (d_qy[k]),
      .pay_i   (d_pay[k]),
      .valid_o (d_v[k+1]),
      .ds_o    (d_ds[k+1]),
      .rx_o    (d_rx[k+1]),
      .ry_o    (d_ry[k+1]),
      .qx_o    (d_qx[k+1]),
      .qy_o    (d_qy[k+1]),
      .pay_o   (d_pay[k+1])
    );
  end

  always_comb begin
    q4   = p4_t'(d_pay[Q]);
    nxw  = NW'(d_qx[Q]);
    nyw  = NW'(d_qy[Q]);
    onew = NW'(1) << NORMAL_FRAC_BITS;
    if (q4.sx) begin
      nxw = -nxw;
    end
    if (q4.sy) begin
      nyw = -nyw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q  <= q4.hit;
      ocx_q  <= q4.hit ? q4.px : '0;
      ocy_q  <= q4.hit ? q4.py : '0;
      odep_q <= q4.hit ? q4.depth : '0;
      if (!q4.hit) begin
        onx_q <= '0;
        ony_q <= '0;
      end else if (q4.near) begin
        onx_q <= '0;
        ony_q <= onew[NORMAL_WIDTH-1:0];
      end else begin
        onx_q <= nxw[NORMAL_WIDTH-1:0];
        ony_q <= nyw[NORMAL_WIDTH-1:0];
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_TW'({odep_q, ony_q, onx_q, ocy_q, ocx_q, hit_q});

endmodule

### rtl/core/cbc_checker.sv
// Port-level checks for the collision block, bound to its top level.
// Depends on cbc_pkg and circle_box_collision_top.
module cbc_checker #(
  parameter int unsigned COORD_BITS = 24
) (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready_o,
  input logic m_axis_tvalid_o,
  input logic m_axis_tready_i,
  input logic [((1+2*COORD_BITS+2*cbc_pkg::NORMAL_WIDTH+COORD_BITS-1+7)/8)*8-1:0]
    m_axis_tdata_o
);
  import cbc_pkg::*;

  localparam int unsigned OUT_W = 1 + 2*COORD_BITS + 2*NORMAL_WIDTH + COORD_BITS - 1;

  // A waiting result beat holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // A miss carries nothing but a cleared hit flag.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[0] |-> m_axis_tdata_o[OUT_W-1:1] == '0)
    else $error("miss beat carries non-zero fields");

  // The input side only stalls while a result waits.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input stalled without a waiting result");

  // No result beat is offered straight after reset.
  a_reset_out: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result beat straight after reset");

endmodule

bind circle_box_collision_top cbc_checker #(.COORD_BITS(COORD_BITS)) u_cbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
